[rtl/dgf_pkg.sv]
// types, constants and scaling functions shared by the diagonal glow filter
`timescale 1ns / 1ps
package dgf_pkg;

   localparam int CH_W         = 16;
   localparam int IMAGE_SIZE_W = 11;
   localparam int IMAGE_SIZE_RST = 1024;
   localparam int CSR_AW       = 3;
   localparam int CSR_DW       = 32;
   localparam logic CSR_IDX_IMAGE_SIZE = 1'b0;

   localparam logic OP_PUSH  = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam int WIN_COLS = 3;
   localparam int OQ_DEPTH = 4;
   localparam int OQ_AW    = 2;
   localparam int OQ_CW    = 3;

   // reciprocal multipliers: floor(3x/10) and floor(4x/25) exact for 16-bit x
   localparam int MUL3_W = 19;
   localparam int MUL4_W = 20;
   localparam logic [MUL3_W-1:0] MUL3 = 19'd314573;
   localparam logic [MUL4_W-1:0] MUL4 = 20'd671089;
   localparam int SHIFT3 = 20;
   localparam int SHIFT4 = 22;
   localparam int P3_W = CH_W + MUL3_W;
   localparam int P4_W = CH_W + MUL4_W;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } pix_type;

   typedef struct packed {
      pix_type top;
      pix_type mid;
      pix_type bot;
   } col_type;

   typedef struct packed {
      pix_type older;
      pix_type newer;
   } line_type;

   typedef struct packed {
      logic up;
      logic down;
      logic left;
      logic right;
      logic last;
   } nbr_type;

   typedef struct packed {
      pix_type pix;
      logic    frame_end;
   } rsp_type;

   function automatic logic [CH_W-1:0] scale3(input logic [CH_W-1:0] x);
      logic [P3_W-1:0] p;
      p = P3_W'(x) * P3_W'(MUL3);
      return CH_W'(p[P3_W-1:SHIFT3]);
   endfunction

   function automatic logic [CH_W-1:0] scale4(input logic [CH_W-1:0] x);
      logic [P4_W-1:0] p;
      p = P4_W'(x) * P4_W'(MUL4);
      return CH_W'(p[P4_W-1:SHIFT4]);
   endfunction

   function automatic pix_type scale3_px(input pix_type x);
      pix_type r;
      r.red   = scale3(x.red);
      r.green = scale3(x.green);
      r.blue  = scale3(x.blue);
      return r;
   endfunction

   function automatic pix_type scale4_px(input pix_type x);
      pix_type r;
      r.red   = scale4(x.red);
      r.green = scale4(x.green);
      r.blue  = scale4(x.blue);
      return r;
   endfunction

endpackage

[rtl/dgf_if.sv]
// valid/ready channel interfaces for pixel requests and filtered responses
`timescale 1ns / 1ps
interface dgf_req_if;
   logic                       valid;
   logic                       ready;
   logic                       operation;
   logic [dgf_pkg::CH_W-1:0]   red_in;
   logic [dgf_pkg::CH_W-1:0]   green_in;
   logic [dgf_pkg::CH_W-1:0]   blue_in;

   modport source (output valid, operation, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, operation, red_in, green_in, blue_in, output ready);
endinterface

interface dgf_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [dgf_pkg::CH_W-1:0]   red_out;
   logic [dgf_pkg::CH_W-1:0]   green_out;
   logic [dgf_pkg::CH_W-1:0]   blue_out;
   logic                       frame_end;

   modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

[rtl/dgf_line.sv]
// dual line store: one entry per column holding the two previous rows
`timescale 1ns / 1ps
module dgf_line #(
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  dgf_pkg::line_type wr_data,
   output dgf_pkg::line_type rd_data
);

   dgf_pkg::line_type mem [DEPTH];
   dgf_pkg::line_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // same-column write in the read cycle is forwarded
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/dgf_cell.sv]
// one window column: holds three weighted taps and hands them to its left neighbour
`timescale 1ns / 1ps
module dgf_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift,
   input  dgf_pkg::col_type col_in,
   output dgf_pkg::col_type col_out
);

   dgf_pkg::col_type col_ff;
   dgf_pkg::col_type col_in_w;

   always_comb begin
      col_in_w = shift ? col_in : col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in_w;
      end
   end

   assign col_out = col_ff;

endmodule

[rtl/dgf_ofifo.sv]
// small output queue that drives the response channel
`timescale 1ns / 1ps
module dgf_ofifo (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  dgf_pkg::rsp_type            push_data,
   output logic [dgf_pkg::OQ_CW-1:0]   count,
   dgf_rsp_if.source                   rsp_chan
);

   dgf_pkg::rsp_type                entry_ff [dgf_pkg::OQ_DEPTH];
   logic [dgf_pkg::OQ_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [dgf_pkg::OQ_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [dgf_pkg::OQ_CW-1:0]       count_ff, count_in;
   logic                            pop;
   dgf_pkg::rsp_type                head;

   assign pop  = rsp_chan.valid && rsp_chan.ready;
   assign head = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + dgf_pkg::OQ_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + dgf_pkg::OQ_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + dgf_pkg::OQ_CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - dgf_pkg::OQ_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign count              = count_ff;
   assign rsp_chan.valid     = (count_ff != '0);
   assign rsp_chan.red_out   = head.pix.red;
   assign rsp_chan.green_out = head.pix.green;
   assign rsp_chan.blue_out  = head.pix.blue;
   assign rsp_chan.frame_end = head.frame_end;

endmodule

[rtl/diagonal_glow_filter_3x3_core.sv]
// top level of the diagonal glow filter: counters, line store, window chain, output queue
//
//   channel    direction  handshake          payload
//   req_chan   in         valid/ready        operation, red_in, green_in, blue_in
//   rsp_chan   out        valid/ready        red_out, green_out, blue_out, frame_end
//   csr_*      in/out     apb, pready high   image_size at byte address 0
//
// one transaction per clock while req_chan.ready is high; the result of the transaction
// that completes its window is queued after the line store read, window chain and sum
// reset is synchronous; image_size returns to 1024 and the line store is not cleared
// a four-entry output queue absorbs rsp_chan stalls; req_chan.ready drops only when
// queued plus in-flight results reach four
`timescale 1ns / 1ps
module diagonal_glow_filter_3x3_core #(
   parameter int MAX_SIZE = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   dgf_req_if.sink                       req_chan,
   dgf_rsp_if.source                     rsp_chan,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [dgf_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [dgf_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [dgf_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);

   localparam int NW    = $clog2(MAX_SIZE + 1);
   localparam int AW    = $clog2(MAX_SIZE);
   localparam int TW    = $clog2(MAX_SIZE * MAX_SIZE + 1);
   localparam int PW    = $clog2(MAX_SIZE * MAX_SIZE + MAX_SIZE + 1);
   localparam int N_RST = (dgf_pkg::IMAGE_SIZE_RST > MAX_SIZE) ? MAX_SIZE
                                                               : dgf_pkg::IMAGE_SIZE_RST;
   localparam int T_RST = N_RST * N_RST;

   logic [dgf_pkg::IMAGE_SIZE_W-1:0] image_size_ff, image_size_in;
   logic [NW-1:0]  n_ff, n_in;
   logic [AW-1:0]  nm1_ff, nm1_in;
   logic [TW-1:0]  total_ff, total_in;
   logic [PW-1:0]  pos_ff, pos_in;
   logic [AW-1:0]  col_ff, col_in;
   logic [AW-1:0]  orow_ff, orow_in;
   logic [AW-1:0]  ocol_ff, ocol_in;

   logic [dgf_pkg::IMAGE_SIZE_W-1:0] cfg_size;
   logic [NW-1:0]  cfg_n;
   logic [TW-1:0]  cfg_total;
   logic [AW-1:0]  cfg_nm1;
   logic           csr_wr;

   logic              acc, take, has_res;
   dgf_pkg::nbr_type  nbr;
   dgf_pkg::pix_type  px;

   logic              s1_vld_ff, s1_res_ff;
   dgf_pkg::nbr_type  s1_nbr_ff;
   dgf_pkg::pix_type  s1_px_ff;
   logic [AW-1:0]     s1_col_ff;
   logic              s2_vld_ff;
   dgf_pkg::nbr_type  s2_nbr_ff;

   dgf_pkg::line_type line_rd, line_wr;
   dgf_pkg::col_type  chain [dgf_pkg::WIN_COLS + 1];
   dgf_pkg::rsp_type  push_data;
   logic [dgf_pkg::OQ_CW-1:0] oq_count;
   logic [dgf_pkg::OQ_CW-1:0] occ;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_prdata = dgf_pkg::CSR_DW'(image_size_ff);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[dgf_pkg::CSR_AW-1] == dgf_pkg::CSR_IDX_IMAGE_SIZE);

   always_comb begin
      cfg_size = csr_pwdata[dgf_pkg::IMAGE_SIZE_W-1:0];
      if (cfg_size == '0) begin
         cfg_n = NW'(1);
      end else if (32'(cfg_size) > 32'(MAX_SIZE)) begin
         cfg_n = NW'(MAX_SIZE);
      end else begin
         cfg_n = NW'(cfg_size);
      end
      cfg_total = TW'(cfg_n) * TW'(cfg_n);
      cfg_nm1   = AW'(cfg_n - NW'(1));
   end

   // frame position and output position
   assign acc     = req_chan.valid && req_chan.ready;
   assign has_res = pos_ff >= (PW'(n_ff) + PW'(1));

   always_comb begin
      if (req_chan.operation == dgf_pkg::OP_DRAIN) begin
         take = acc && (pos_ff >= PW'(total_ff));
      end else begin
         take = acc && (pos_ff < PW'(total_ff));
      end
      nbr.up    = (orow_ff != '0);
      nbr.down  = (orow_ff != nm1_ff);
      nbr.left  = (ocol_ff != '0);
      nbr.right = (ocol_ff != nm1_ff);
      nbr.last  = (orow_ff == nm1_ff) && (ocol_ff == nm1_ff);
      if (req_chan.operation == dgf_pkg::OP_DRAIN) begin
         px = '0;
      end else begin
         px.red   = req_chan.red_in;
         px.green = req_chan.green_in;
         px.blue  = req_chan.blue_in;
      end
   end

   always_comb begin
      image_size_in = image_size_ff;
      n_in          = n_ff;
      nm1_in        = nm1_ff;
      total_in      = total_ff;
      pos_in        = pos_ff;
      col_in        = col_ff;
      orow_in       = orow_ff;
      ocol_in       = ocol_ff;
      if (csr_wr) begin
         image_size_in = cfg_size;
         n_in          = cfg_n;
         nm1_in        = cfg_nm1;
         total_in      = cfg_total;
         pos_in        = '0;
         col_in        = '0;
         orow_in       = '0;
         ocol_in       = '0;
      end else if (take) begin
         pos_in = pos_ff + PW'(1);
         col_in = (col_ff == nm1_ff) ? '0 : col_ff + AW'(1);
         if (has_res) begin
            if (nbr.last) begin
               pos_in  = '0;
               col_in  = '0;
               orow_in = '0;
               ocol_in = '0;
            end else if (ocol_ff == nm1_ff) begin
               ocol_in = '0;
               orow_in = orow_ff + AW'(1);
            end else begin
               ocol_in = ocol_ff + AW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_size_ff <= dgf_pkg::IMAGE_SIZE_W'(dgf_pkg::IMAGE_SIZE_RST);
         n_ff          <= NW'(N_RST);
         nm1_ff        <= AW'(N_RST - 1);
         total_ff      <= TW'(T_RST);
         pos_ff        <= '0;
         col_ff        <= '0;
         orow_ff       <= '0;
         ocol_ff       <= '0;
      end else begin
         image_size_ff <= image_size_in;
         n_ff          <= n_in;
         nm1_ff        <= nm1_in;
         total_ff      <= total_in;
         pos_ff        <= pos_in;
         col_ff        <= col_in;
         orow_ff       <= orow_in;
         ocol_ff       <= ocol_in;
      end
   end

   // stage 1: line store read is in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s1_res_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= take;
         s1_res_ff <= take && has_res;
         s2_vld_ff <= s1_vld_ff && s1_res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_nbr_ff <= nbr;
         s1_px_ff  <= px;
         s1_col_ff <= col_ff;
      end
      if (s1_vld_ff) begin
         s2_nbr_ff <= s1_nbr_ff;
      end
   end

   assign line_wr.older = line_rd.newer;
   assign line_wr.newer = s1_px_ff;

   dgf_line #(
      .DEPTH (MAX_SIZE)
   ) u_line (
      .clock   (clock),
      .rd_en   (take),
      .rd_addr (col_ff),
      .wr_en   (s1_vld_ff),
      .wr_addr (s1_col_ff),
      .wr_data (line_wr),
      .rd_data (line_rd)
   );

   // new column enters the chain already weighted
   always_comb begin
      chain[dgf_pkg::WIN_COLS].top = dgf_pkg::scale4_px(line_rd.older);
      chain[dgf_pkg::WIN_COLS].mid = dgf_pkg::scale3_px(line_rd.newer);
      chain[dgf_pkg::WIN_COLS].bot = dgf_pkg::scale4_px(s1_px_ff);
   end

   for (genvar i = 0; i < dgf_pkg::WIN_COLS; i++) begin : g_win
      dgf_cell u_col (
         .clock   (clock),
         .reset   (reset),
         .shift   (s1_vld_ff),
         .col_in  (chain[i + 1]),
         .col_out (chain[i])
      );
   end

   // stage 2: centre plus the diagonals that lie inside the frame
   function automatic logic [dgf_pkg::CH_W-1:0] glow(
      input logic [dgf_pkg::CH_W-1:0] ctr,
      input logic [dgf_pkg::CH_W-1:0] ul,
      input logic [dgf_pkg::CH_W-1:0] ur,
      input logic [dgf_pkg::CH_W-1:0] dl,
      input logic [dgf_pkg::CH_W-1:0] dr,
      input dgf_pkg::nbr_type         nb
   );
      logic [dgf_pkg::CH_W-1:0] s;
      s = ctr;
      if (nb.up && nb.left)    s = s + ul;
      if (nb.up && nb.right)   s = s + ur;
      if (nb.down && nb.left)  s = s + dl;
      if (nb.down && nb.right) s = s + dr;
      return s;
   endfunction

   always_comb begin
      push_data.pix.red   = glow(chain[1].mid.red, chain[0].top.red, chain[2].top.red,
                                 chain[0].bot.red, chain[2].bot.red, s2_nbr_ff);
      push_data.pix.green = glow(chain[1].mid.green, chain[0].top.green, chain[2].top.green,
                                 chain[0].bot.green, chain[2].bot.green, s2_nbr_ff);
      push_data.pix.blue  = glow(chain[1].mid.blue, chain[0].top.blue, chain[2].top.blue,
                                 chain[0].bot.blue, chain[2].bot.blue, s2_nbr_ff);
      push_data.frame_end = s2_nbr_ff.last;
   end

   dgf_ofifo u_ofifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_vld_ff),
      .push_data (push_data),
      .count     (oq_count),
      .rsp_chan  (rsp_chan)
   );

   // credit: results queued or still in the pipeline
   assign occ = oq_count + dgf_pkg::OQ_CW'(s1_vld_ff && s1_res_ff)
                + dgf_pkg::OQ_CW'(s2_vld_ff);
   assign req_chan.ready = (occ < dgf_pkg::OQ_CW'(dgf_pkg::OQ_DEPTH));

endmodule
